[sv/tfbs_pkg.sv]
// Shared types, byte codes and defaults for the telemetry field byte stuffer.
package tfbs_pkg;

   localparam logic [7:0] MARK_BYTE   = 8'h5E;
   localparam logic [7:0] ESC_BYTE    = 8'h5D;
   localparam logic [7:0] ESC_OF_MARK = 8'h3E;
   localparam logic [7:0] ESC_OF_ESC  = 8'h3D;

   localparam int TFBS_QUEUE_DEPTH = 4;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_TAIL = 1'b1;

   // Classified request as it travels from front to back.
   typedef struct packed {
      logic       is_tail;
      logic [7:0] id;
      logic       lo_esc;
      logic [7:0] lo_first;
      logic [7:0] lo_second;
      logic       hi_esc;
      logic [7:0] hi_first;
      logic [7:0] hi_second;
   } tfbs_cmd_type;

   typedef enum logic [2:0] {
      STEP_HDR,
      STEP_ID,
      STEP_LO_A,
      STEP_LO_B,
      STEP_HI_A,
      STEP_HI_B
   } tfbs_step_type;

   // Status of the queue as seen by its neighbors.
   typedef struct packed {
      logic full;
      logic valid;
   } tfbs_qstat_type;

   function automatic logic needs_esc(input logic [7:0] b);
      needs_esc = (b == MARK_BYTE) || (b == ESC_BYTE);
   endfunction

   function automatic logic [7:0] esc_code(input logic [7:0] b);
      esc_code = (b == MARK_BYTE) ? ESC_OF_MARK : ESC_OF_ESC;
   endfunction

endpackage

[sv/tfbs_front.sv]
// Front end: accepts requests and classifies them into stuffing commands.
module tfbs_front import tfbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic [7:0]           req_field_id,
   input  logic [15:0]          req_field_value,
   input  tfbs_qstat_type       qstat,
   output logic                 push,
   output tfbs_cmd_type         push_cmd
);

   logic         valid_ff, valid_in;
   tfbs_cmd_type cmd_ff, cmd_in;
   logic         accept;
   logic [7:0]   lo, hi;

   assign lo = req_field_value[7:0];
   assign hi = req_field_value[15:8];

   assign push      = valid_ff && !qstat.full;
   assign req_stall = valid_ff && qstat.full;
   assign accept    = req_valid && !req_stall;
   assign push_cmd  = cmd_ff;

   always_comb begin
      cmd_in.is_tail   = (req_kind == KIND_TAIL);
      cmd_in.id        = req_field_id;
      cmd_in.lo_esc    = needs_esc(lo);
      cmd_in.lo_first  = needs_esc(lo) ? ESC_BYTE : lo;
      cmd_in.lo_second = esc_code(lo);
      cmd_in.hi_esc    = needs_esc(hi);
      cmd_in.hi_first  = needs_esc(hi) ? ESC_BYTE : hi;
      cmd_in.hi_second = esc_code(hi);
   end

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

[sv/tfbs_queue.sv]
// Short command queue between the front end and the byte sequencer.
module tfbs_queue import tfbs_pkg::*; #(
   parameter int QueueDepth = TFBS_QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  tfbs_cmd_type   push_cmd,
   input  logic           pop,
   output tfbs_cmd_type   head_cmd,
   output tfbs_qstat_type qstat
);

   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr = PtrWidth'(QueueDepth - 1);
   localparam logic [CountWidth-1:0] Full   = CountWidth'(QueueDepth);

   tfbs_cmd_type          entry_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign qstat.full  = (count_ff == Full);
   assign qstat.valid = (count_ff != '0);
   assign head_cmd    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/tfbs_back.sv]
// Back end: steps through each command and emits one byte per cycle while the output is not stalled.
module tfbs_back import tfbs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  tfbs_qstat_type qstat,
   input  tfbs_cmd_type   head_cmd,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_last_byte
);

   tfbs_step_type step_ff, step_in;
   logic          busy_ff, busy_in;
   tfbs_cmd_type  cur_ff, cur_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_last_ff, out_last_in;
   tfbs_cmd_type  cur;
   logic          have, advance;
   tfbs_step_type next_step;

   assign cur     = busy_ff ? cur_ff : head_cmd;
   assign have    = busy_ff || qstat.valid;
   assign advance = have && (!out_valid_ff || !rsp_stall);
   assign pop     = advance && !busy_ff;

   always_comb begin
      out_byte_in = MARK_BYTE;
      out_last_in = 1'b0;
      next_step   = STEP_HDR;
      unique case (step_ff)
         STEP_HDR: begin
            out_byte_in = MARK_BYTE;
            out_last_in = cur.is_tail;
            next_step   = STEP_ID;
         end
         STEP_ID: begin
            out_byte_in = cur.id;
            next_step   = STEP_LO_A;
         end
         STEP_LO_A: begin
            out_byte_in = cur.lo_first;
            next_step   = cur.lo_esc ? STEP_LO_B : STEP_HI_A;
         end
         STEP_LO_B: begin
            out_byte_in = cur.lo_second;
            next_step   = STEP_HI_A;
         end
         STEP_HI_A: begin
            out_byte_in = cur.hi_first;
            out_last_in = !cur.hi_esc;
            next_step   = STEP_HI_B;
         end
         STEP_HI_B: begin
            out_byte_in = cur.hi_second;
            out_last_in = 1'b1;
         end
         default: begin
            out_last_in = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      busy_in      = busy_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         cur_in       = cur;
         // close the run on its last byte and fetch the next command at once
         if (out_last_in) begin
            busy_in = 1'b0;
            step_in = STEP_HDR;
         end else begin
            busy_in = 1'b1;
            step_in = next_step;
         end
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_HDR;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff <= cur_in;
      if (advance) begin
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_last_byte = out_last_ff;

endmodule

[sv/telemetry_field_byte_stuffer.sv]
// Telemetry field byte stuffer: top level joining front end, queue and byte sequencer.
// Each request expands to a run of link bytes: a tail request gives the single
// byte 0x5E, a data request gives 0x5E, the id as is, then the low and high value
// bytes with 0x5E and 0x5D stuffed as 0x5D 0x3E and 0x5D 0x3D; the final byte of
// a run carries rsp_last_byte. The byte sequencer drives one byte per cycle while
// rsp_stall is low, so a data request gives 4 to 6 output bytes and a tail request
// 1, and runs follow each other with no gap. The first byte of a request passes
// from the front register into the queue and then into the output register. The
// queue holds QueueDepth classified requests, so requests keep being accepted
// while the output is stalled until the queue fills.
module telemetry_field_byte_stuffer import tfbs_pkg::*; #(
   parameter int QueueDepth = TFBS_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_field_id,
   input  logic [15:0] req_field_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte
);

   tfbs_qstat_type qstat;
   tfbs_cmd_type   push_cmd, head_cmd;
   logic           push, pop;

   tfbs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_field_id    (req_field_id),
      .req_field_value (req_field_value),
      .qstat           (qstat),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   tfbs_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .qstat    (qstat)
   );

   tfbs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .qstat         (qstat),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   // never write into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full))
      else $error("push into full queue");

   // a 0x5D byte is either an escape followed by its code or an id, so it never ends a run
   a_esc_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_byte == ESC_BYTE) |-> !rsp_last_byte)
      else $error("escape byte marked last");

   // a run in progress keeps the output busy until its last byte
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_byte) |=> rsp_valid)
      else $error("gap inside a run");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the telemetry field byte stuffer.
module testbench;
   import tfbs_pkg::*;

   localparam int NUM_RANDOM   = 350;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int NUM_DIRECTED = 18;

   // One stimulus row; typed_count of zero means the predictor supplies the run.
   typedef struct packed {
      logic        kind;
      logic [7:0]  id;
      logic [15:0] value;
      logic [2:0]  typed_count;
      logic [47:0] typed_run;
   } stim_row_t;

   typedef struct packed {
      logic [7:0] link_byte;
      logic       last;
   } link_byte_t;

   localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{KIND_TAIL, 8'h00, 16'h0000, 3'd1, {MARK_BYTE, 40'h0}},
      '{KIND_DATA, 8'h00, 16'h0000, 3'd4, {MARK_BYTE, 8'h00, 8'h00, 8'h00, 16'h0}},
      '{KIND_DATA, 8'hFF, 16'hFFFF, 3'd4, {MARK_BYTE, 8'hFF, 8'hFF, 8'hFF, 16'h0}},
      '{KIND_TAIL, 8'hFF, 16'hFFFF, 3'd1, {MARK_BYTE, 40'h0}},
      // marker values in the id go out unstuffed
      '{KIND_DATA, MARK_BYTE, 16'h1234, 3'd4, {MARK_BYTE, MARK_BYTE, 8'h34, 8'h12, 16'h0}},
      '{KIND_DATA, ESC_BYTE, 16'h0000, 3'd4, {MARK_BYTE, ESC_BYTE, 8'h00, 8'h00, 16'h0}},
      '{KIND_DATA, 8'h01, {8'h00, MARK_BYTE}, 3'd5,
        {MARK_BYTE, 8'h01, ESC_BYTE, ESC_OF_MARK, 8'h00, 8'h00}},
      '{KIND_DATA, 8'h02, {ESC_BYTE, 8'h00}, 3'd5,
        {MARK_BYTE, 8'h02, 8'h00, ESC_BYTE, ESC_OF_ESC, 8'h00}},
      '{KIND_DATA, 8'h03, {MARK_BYTE, MARK_BYTE}, 3'd6,
        {MARK_BYTE, 8'h03, ESC_BYTE, ESC_OF_MARK, ESC_BYTE, ESC_OF_MARK}},
      '{KIND_DATA, 8'h04, {ESC_BYTE, ESC_BYTE}, 3'd6,
        {MARK_BYTE, 8'h04, ESC_BYTE, ESC_OF_ESC, ESC_BYTE, ESC_OF_ESC}},
      '{KIND_DATA, 8'h05, {ESC_BYTE, MARK_BYTE}, 3'd6,
        {MARK_BYTE, 8'h05, ESC_BYTE, ESC_OF_MARK, ESC_BYTE, ESC_OF_ESC}},
      '{KIND_DATA, ESC_OF_MARK, {ESC_OF_ESC, ESC_OF_MARK}, 3'd0, 48'h0},
      '{KIND_DATA, ESC_BYTE, 16'h5F5C, 3'd0, 48'h0},
      '{KIND_DATA, 8'hA5, 16'h8001, 3'd0, 48'h0},
      '{KIND_TAIL, MARK_BYTE, {MARK_BYTE, ESC_BYTE}, 3'd0, 48'h0},
      '{KIND_DATA, 8'h80, 16'h7FFF, 3'd0, 48'h0},
      '{KIND_DATA, 8'h7F, 16'h0180, 3'd0, 48'h0},
      '{KIND_DATA, MARK_BYTE, {ESC_BYTE, MARK_BYTE}, 3'd0, 48'h0}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [7:0]  req_field_id;
   logic [15:0] req_field_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_byte;

   link_byte_t bytes_due [$];
   int         fail_count = 0;
   int         cycle_count = 0;
   int         burst_left = 0;

   telemetry_field_byte_stuffer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_field_id    (req_field_id),
      .req_field_value (req_field_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stuff one value byte into the link stream.
   function automatic void push_value_byte(input logic [7:0] b, input logic last);
      if (b == MARK_BYTE || b == ESC_BYTE) begin
         bytes_due.push_back('{ESC_BYTE, 1'b0});
         bytes_due.push_back('{(b == MARK_BYTE) ? ESC_OF_MARK : ESC_OF_ESC, last});
      end else begin
         bytes_due.push_back('{b, last});
      end
   endfunction

   // Predict the link bytes that one request expands into.
   function automatic void expand_request(input logic kind, input logic [7:0] id,
                                          input logic [15:0] value);
      if (kind == KIND_TAIL) begin
         bytes_due.push_back('{MARK_BYTE, 1'b1});
      end else begin
         bytes_due.push_back('{MARK_BYTE, 1'b0});
         bytes_due.push_back('{id, 1'b0});
         push_value_byte(value[7:0], 1'b0);
         push_value_byte(value[15:8], 1'b1);
      end
   endfunction

   // Bias toward the marker and escape codes so stuffing is hit often.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: pick_byte = MARK_BYTE;
         1: pick_byte = ESC_BYTE;
         2: pick_byte = ESC_OF_MARK;
         3: pick_byte = ESC_OF_ESC;
         default: pick_byte = 8'($urandom);
      endcase
   endfunction

   // Start a new burst when the current one is used up, usually after a gap.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   // Present one request and hold it until the block takes it.
   task automatic send_request(input stim_row_t row);
      int k;
      pace_sender();
      @(negedge clock);
      req_valid       <= 1'b1;
      req_kind        <= row.kind;
      req_field_id    <= row.id;
      req_field_value <= row.value;
      do @(posedge clock); while (req_stall);
      if (row.typed_count == 0) begin
         expand_request(row.kind, row.id, row.value);
      end else begin
         for (k = 0; k < row.typed_count; k++)
            bytes_due.push_back('{row.typed_run[47 - 8*k -: 8], k == row.typed_count - 1});
      end
   endtask

   // Receiver: pick a new stall pattern each time stall_phase wraps.
   int         stall_mode = 0;
   logic [5:0] stall_phase = '0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_phase == 6'd47) begin
            stall_phase <= '0;
            stall_mode  <= $urandom_range(0, 3);
         end else begin
            stall_phase <= stall_phase + 1'b1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= stall_phase[2];
         endcase
      end
   end

   always @(posedge clock) begin
      link_byte_t due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bytes_due.size() == 0) begin
            $display("%0t: unexpected byte %h last %b", $time, rsp_out_byte, rsp_last_byte);
            fail_count++;
         end else begin
            due = bytes_due.pop_front();
            if (rsp_out_byte !== due.link_byte) begin
               $display("%0t: out_byte mismatch: expected %h, actual %h",
                        $time, due.link_byte, rsp_out_byte);
               fail_count++;
            end
            if (rsp_last_byte !== due.last) begin
               $display("%0t: last_byte mismatch: expected %b, actual %b",
                        $time, due.last, rsp_last_byte);
               fail_count++;
            end
         end
      end
   end

   initial begin
      stim_row_t row;
      int i;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = KIND_DATA;
      req_field_id    = '0;
      req_field_value = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIRECTED; i++) send_request(DIRECTED_ROWS[i]);
      wait_drained();

      for (i = 0; i < NUM_RANDOM; i++) begin
         row.kind        = ($urandom_range(0, 4) == 0) ? KIND_TAIL : KIND_DATA;
         row.id          = pick_byte();
         row.value       = {pick_byte(), pick_byte()};
         row.typed_count = '0;
         row.typed_run   = '0;
         send_request(row);
         // hold off until the link has caught up
         if (i == NUM_RANDOM / 2) wait_drained();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
